@@ hw/rtl/pbc_pkg.sv @@
// Package for the particle boundary condition block: particle and pipeline stage types,
// register indexes, boundary mode codes and the saturation helpers.
// Depends on nothing; the top level imports it.
package pbc_pkg;

   localparam int unsigned Q_W    = 32;
   localparam int unsigned PROD_W = 48;
   localparam int unsigned SUM_W  = 49;
   localparam int unsigned WRAP_W = 34;
   localparam int unsigned AXES   = 3;

   localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

   localparam logic [5:0]     MODES_RESET = 6'd21;
   localparam logic [Q_W-1:0] LOW_RESET   = '0;
   localparam logic [Q_W-1:0] HIGH_RESET  = Q_MAX;
   localparam logic [Q_W-1:0] DT_RESET    = '0;

   typedef enum logic [1:0] {
      MODE_PERIODIC = 2'd0,
      MODE_SLIP     = 2'd1,
      MODE_NO_SLIP  = 2'd2,
      MODE_THERMAL  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_AXIS_MODES = 3'd0,
      CSR_X_LOW      = 3'd1,
      CSR_X_HIGH     = 3'd2,
      CSR_Y_LOW      = 3'd3,
      CSR_Y_HIGH     = 3'd4,
      CSR_Z_LOW      = 3'd5,
      CSR_Z_HIGH     = 3'd6,
      CSR_TIME_STEP  = 3'd7
   } csr_type;

   typedef struct packed {
      logic [AXES-1:0][Q_W-1:0] pos;
      logic [AXES-1:0][Q_W-1:0] vel;
   } particle_type;

   typedef struct packed {
      particle_type p;
      logic         hit;
      logic         wrap_sub;
      logic         wrap_add;
   } chk_type;

   typedef struct packed {
      particle_type                p;
      logic                        hit;
      logic                        wrap;
      logic [AXES-1:0][PROD_W-1:0] prod;
      logic [WRAP_W-1:0]           wrap_sum;
   } mul_type;

   // Axis handled by pipeline section g: y first, then x, then z.
   function automatic logic [1:0] axis_at(input int g);
      logic [1:0] ax;
      case (g)
         0:       ax = 2'd1;
         1:       ax = 2'd0;
         default: ax = 2'd2;
      endcase
      return ax;
   endfunction

   function automatic logic [Q_W-1:0] sat_q(input logic [SUM_W-1:0] v);
      logic [Q_W-1:0] r;
      if ((&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1])) begin
         r = v[Q_W-1:0];
      end else begin
         r = v[SUM_W-1] ? Q_MIN : Q_MAX;
      end
      return r;
   endfunction

   function automatic logic [Q_W-1:0] neg_sat(input logic [Q_W-1:0] v);
      logic [Q_W-1:0] r;
      if (v == Q_MIN) begin
         r = Q_MAX;
      end else begin
         r = Q_W'(-$signed(v));
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/particle_boundary_condition.sv @@
// Top level of the particle boundary condition block: nine-stage pipeline, three stages per
// axis (test and reflect, multiply, add and saturate), plus the configuration registers.
// Depends on pbc_pkg.
//
//   channel | direction | ports                                   | beat
//   req     | in        | req_valid/req_ready, req_pos_*, req_vel_* | one particle
//   rsp     | out       | rsp_valid/rsp_ready, rsp_new_pos_*, ...   | one updated particle
//   csr     | in        | csr_valid/csr_ready, csr_index, csr_data  | one register write
//
// One particle enters per cycle while no stall holds the pipeline; its result passes the
// stage registers of y, then x, then z, and leaves as one response beat.
// Every stage takes a new beat each cycle unless it is full and the stage after it stalls;
// the three 33x33 multipliers of each axis sit in its multiply stage.
// Reset clears all stage valid bits and loads the register reset values.
// Each stage holds its beat while the next stage is full and stalled, so bubbles collapse
// and a stalled output still lets earlier stages fill.
module particle_boundary_condition
   import pbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_pos_z,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [5:0]     modes_ff;
   logic [Q_W-1:0] low_ff  [AXES];
   logic [Q_W-1:0] high_ff [AXES];
   logic [Q_W-1:0] dt_ff;

   particle_type in_p;
   particle_type src_p   [AXES];
   logic         src_vld [AXES];

   chk_type      a_in     [AXES];
   chk_type      a_ff     [AXES];
   logic         a_vld_ff [AXES];
   mul_type      b_in     [AXES];
   mul_type      b_ff     [AXES];
   logic         b_vld_ff [AXES];
   particle_type c_in     [AXES];
   particle_type c_ff     [AXES];
   logic         c_vld_ff [AXES];

   logic en_a [AXES];
   logic en_b [AXES];
   logic en_c [AXES];

   logic [3*AXES-1:0] occ;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff <= MODES_RESET;
         for (int k = 0; k < AXES; k++) begin
            low_ff[k]  <= LOW_RESET;
            high_ff[k] <= HIGH_RESET;
         end
         dt_ff <= DT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_type'(csr_index))
            CSR_AXIS_MODES: modes_ff   <= csr_data[5:0];
            CSR_X_LOW:      low_ff[0]  <= csr_data;
            CSR_X_HIGH:     high_ff[0] <= csr_data;
            CSR_Y_LOW:      low_ff[1]  <= csr_data;
            CSR_Y_HIGH:     high_ff[1] <= csr_data;
            CSR_Z_LOW:      low_ff[2]  <= csr_data;
            CSR_Z_HIGH:     high_ff[2] <= csr_data;
            CSR_TIME_STEP:  dt_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   assign in_p.pos[0] = req_pos_x;
   assign in_p.pos[1] = req_pos_y;
   assign in_p.pos[2] = req_pos_z;
   assign in_p.vel[0] = req_vel_x;
   assign in_p.vel[1] = req_vel_y;
   assign in_p.vel[2] = req_vel_z;

   assign req_ready = en_a[0];

   for (genvar g = 0; g < AXES; g++) begin : gen_axis
      localparam logic [1:0] AX = axis_at(g);

      mode_type mode;
      logic     gt;
      logic     lt;

      if (g == 0) begin : gen_src_in
         assign src_p[g]   = in_p;
         assign src_vld[g] = req_valid;
      end else begin : gen_src_prev
         assign src_p[g]   = c_ff[g-1];
         assign src_vld[g] = c_vld_ff[g-1];
      end

      if (g == AXES - 1) begin : gen_en_last
         assign en_c[g] = !c_vld_ff[g] || rsp_ready;
      end else begin : gen_en_mid
         assign en_c[g] = !c_vld_ff[g] || en_a[g+1];
      end
      assign en_b[g] = !b_vld_ff[g] || en_c[g];
      assign en_a[g] = !a_vld_ff[g] || en_b[g];

      assign mode = mode_type'(modes_ff[2*AX +: 2]);
      assign gt   = $signed(src_p[g].pos[AX]) > $signed(high_ff[AX]);
      assign lt   = $signed(src_p[g].pos[AX]) < $signed(low_ff[AX]);

      always_comb begin
         a_in[g].p        = src_p[g];
         a_in[g].hit      = 1'b0;
         a_in[g].wrap_sub = 1'b0;
         a_in[g].wrap_add = 1'b0;
         case (mode)
            MODE_PERIODIC: begin
               a_in[g].wrap_sub = gt;
               a_in[g].wrap_add = !gt && lt;
            end
            MODE_NO_SLIP: begin
               if (gt || lt) begin
                  a_in[g].hit = 1'b1;
                  for (int k = 0; k < AXES; k++) begin
                     a_in[g].p.vel[k] = neg_sat(src_p[g].vel[k]);
                  end
               end
            end
            default: ;
         endcase
      end

      always_comb begin
         logic signed [65:0]       full;
         logic signed [Q_W:0]      span;
         logic signed [WRAP_W-1:0] cext;
         b_in[g].p    = a_ff[g].p;
         b_in[g].hit  = a_ff[g].hit;
         b_in[g].wrap = a_ff[g].wrap_sub || a_ff[g].wrap_add;
         for (int k = 0; k < AXES; k++) begin
            full = $signed({a_ff[g].p.vel[k][Q_W-1], a_ff[g].p.vel[k]})
                 * $signed({1'b0, dt_ff});
            b_in[g].prod[k] = full[63:16];
         end
         span = $signed({high_ff[AX][Q_W-1], high_ff[AX]})
              - $signed({low_ff[AX][Q_W-1], low_ff[AX]});
         cext = $signed({{2{a_ff[g].p.pos[AX][Q_W-1]}}, a_ff[g].p.pos[AX]});
         if (a_ff[g].wrap_sub) begin
            b_in[g].wrap_sum = cext - WRAP_W'(span);
         end else begin
            b_in[g].wrap_sum = cext + WRAP_W'(span);
         end
      end

      always_comb begin
         logic [SUM_W-1:0] sum;
         sum     = '0;
         c_in[g] = b_ff[g].p;
         if (b_ff[g].hit) begin
            for (int k = 0; k < AXES; k++) begin
               sum = {{(SUM_W-Q_W){b_ff[g].p.pos[k][Q_W-1]}}, b_ff[g].p.pos[k]}
                   + {b_ff[g].prod[k][PROD_W-1], b_ff[g].prod[k]};
               c_in[g].pos[k] = sat_q(sum);
            end
         end
         if (b_ff[g].wrap) begin
            c_in[g].pos[AX] = sat_q({{(SUM_W-WRAP_W){b_ff[g].wrap_sum[WRAP_W-1]}},
                                     b_ff[g].wrap_sum});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_vld_ff[g] <= 1'b0;
            b_vld_ff[g] <= 1'b0;
            c_vld_ff[g] <= 1'b0;
         end else begin
            if (en_a[g]) begin
               a_vld_ff[g] <= src_vld[g];
            end
            if (en_b[g]) begin
               b_vld_ff[g] <= a_vld_ff[g];
            end
            if (en_c[g]) begin
               c_vld_ff[g] <= b_vld_ff[g];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en_a[g]) begin
            a_ff[g] <= a_in[g];
         end
         if (en_b[g]) begin
            b_ff[g] <= b_in[g];
         end
         if (en_c[g]) begin
            c_ff[g] <= c_in[g];
         end
      end

      assign occ[3*g]   = a_vld_ff[g];
      assign occ[3*g+1] = b_vld_ff[g];
      assign occ[3*g+2] = c_vld_ff[g];
   end

   assign rsp_valid     = c_vld_ff[AXES-1];
   assign rsp_new_pos_x = $signed(c_ff[AXES-1].pos[0]);
   assign rsp_new_pos_y = $signed(c_ff[AXES-1].pos[1]);
   assign rsp_new_pos_z = $signed(c_ff[AXES-1].pos[2]);
   assign rsp_new_vel_x = $signed(c_ff[AXES-1].vel[0]);
   assign rsp_new_vel_y = $signed(c_ff[AXES-1].vel[1]);
   assign rsp_new_vel_z = $signed(c_ff[AXES-1].vel[2]);

   // The number of beats in flight changes only by what enters and what leaves.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(occ) == $past($countones(occ))
         + int'($past(req_valid && req_ready)) - int'($past(rsp_valid && rsp_ready)))
      else $error("pipeline occupancy does not match accepted and delivered beats");

   // An axis applies at most one of its rules to a beat.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({a_ff[0].hit, a_ff[0].wrap_sub, a_ff[0].wrap_add})
      && $onehot0({a_ff[1].hit, a_ff[1].wrap_sub, a_ff[1].wrap_add})
      && $onehot0({a_ff[2].hit, a_ff[2].wrap_sub, a_ff[2].wrap_add}))
      else $error("more than one boundary rule flagged on one axis");

   // With the output stalled, input is taken only while some stage is empty.
   assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid && !rsp_ready) |-> !(&occ))
      else $error("input accepted into a full stalled pipeline");

endmodule
